// ----- hw/rtl/rspan_pkg.sv -----
`timescale 1ns / 1ps

package rspan_pkg;

  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int FracBits  = 4;

  localparam int PixW   = 8;
  localparam int OrigW  = 16;
  localparam int PosW   = 17;
  localparam int SpanWW = 9;
  localparam int CfgW   = 8;
  localparam int CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBaseAlpha = 1'b1;

  localparam logic [CfgW-1:0] ThresholdReset = 8'd48;
  localparam logic [CfgW-1:0] BaseAlphaReset = 8'd255;

  typedef struct packed {
    logic [PixW-1:0]         alpha;
    logic                    row_end;
    logic                    glyph_end;
    logic signed [OrigW-1:0] origin_x;
    logic signed [OrigW-1:0] origin_y;
  } pixel_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [SpanWW-1:0]      width;
    logic [PixW-1:0]        peak;
  } span_t;

endpackage

// ----- hw/rtl/alpha_row_span_extractor.sv -----
`timescale 1ns / 1ps
// channel   | handshake               | payload
// pixel in  | in_valid_i / in_ready_o | pixel_alpha_i row_end_i glyph_end_i origin_x_i origin_y_i
// span out  | out_valid_o/out_ready_i | span_x_o span_y_o span_width_o span_alpha_o
// config    | cfg_we_i (no wait)      | cfg_index_i cfg_data_i
//
// one pixel per cycle sustained while the span output is not stalled; a span is valid on the output
// after the request that closes its run has gone from the input register into the result register
// run tracking updates once per pixel as it leaves the input register
// reset: threshold 48, base alpha 255, column, row and run state cleared
// a stalled span holds in the result register; the input register then fills and
// in_ready_o drops until the span is taken

module alpha_row_span_extractor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [rspan_pkg::PixW-1:0]           pixel_alpha_i,
  input  logic                                 row_end_i,
  input  logic                                 glyph_end_i,
  input  logic signed [rspan_pkg::OrigW-1:0]   origin_x_i,
  input  logic signed [rspan_pkg::OrigW-1:0]   origin_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rspan_pkg::PosW-1:0]    span_x_o,
  output logic signed [rspan_pkg::PosW-1:0]    span_y_o,
  output logic [rspan_pkg::SpanWW-1:0]         span_width_o,
  output logic [rspan_pkg::PixW-1:0]           span_alpha_o,
  input  logic                                 cfg_we_i,
  input  logic [rspan_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [rspan_pkg::CfgW-1:0]           cfg_data_i
);
  import rspan_pkg::*;

  logic [CfgW-1:0] threshold_q, base_alpha_q;

  pixel_t pix_in, pix_s1;
  span_t  span;
  logic   s1_valid;
  logic   res_free;
  logic   advance;
  logic   emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= ThresholdReset;
      base_alpha_q <= BaseAlphaReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgThreshold: threshold_q  <= cfg_data_i;
        CfgBaseAlpha: base_alpha_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pix_in.alpha     = pixel_alpha_i;
    pix_in.row_end   = row_end_i;
    pix_in.glyph_end = glyph_end_i;
    pix_in.origin_x  = origin_x_i;
    pix_in.origin_y  = origin_y_i;
  end

  assign advance = s1_valid && res_free;

  rspan_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pix_i      (pix_in),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .pix_o      (pix_s1)
  );

  rspan_tracker u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .pix_i       (pix_s1),
    .threshold_i (threshold_q),
    .emit_o      (emit),
    .span_o      (span)
  );

  rspan_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && emit),
    .span_i       (span),
    .base_alpha_i (base_alpha_q),
    .free_o       (res_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .span_x_o     (span_x_o),
    .span_y_o     (span_y_o),
    .span_width_o (span_width_o),
    .span_alpha_o (span_alpha_o)
  );

  a_width_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (span_width_o != '0))
    else $error("span with zero width");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> in_ready_o)
    else $error("empty input register refuses a request");

  a_new_span_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> out_valid_o)
    else $error("span lost on its way to the result register");

endmodule

// ----- hw/rtl/rspan_in_stage.sv -----
`timescale 1ns / 1ps

module rspan_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rspan_pkg::pixel_t pix_i,
  input  logic              advance_i,
  output logic              valid_o,
  output rspan_pkg::pixel_t pix_o
);
  import rspan_pkg::*;

  logic   valid_q, valid_d;
  pixel_t pix_q;
  logic   accept;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_i;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

// ----- hw/rtl/rspan_tracker.sv -----
`timescale 1ns / 1ps

module rspan_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  rspan_pkg::pixel_t          pix_i,
  input  logic [rspan_pkg::CfgW-1:0] threshold_i,
  output logic                       emit_o,
  output rspan_pkg::span_t           span_o
);
  import rspan_pkg::*;

  logic [ColW-1:0] column_q, column_d;
  logic [RowW-1:0] row_q, row_d;
  logic            open_q, open_d;
  logic [ColW-1:0] start_q, start_d;
  logic [PixW-1:0] peak_q, peak_d;

  logic            above;
  logic            line_end;
  logic [ColW-1:0] start_eff;
  logic [PixW-1:0] peak_eff;
  logic [PixW-1:0] peak_out;

  assign above    = pix_i.alpha > threshold_i;
  assign line_end = pix_i.row_end || pix_i.glyph_end ||
                    (column_q == ColW'(MaxWidth - 1));

  always_comb begin
    start_eff = open_q ? start_q : column_q;
    if (!open_q) begin
      peak_eff = pix_i.alpha;
    end else if (pix_i.alpha > peak_q) begin
      peak_eff = pix_i.alpha;
    end else begin
      peak_eff = peak_q;
    end
    peak_out = above ? peak_eff : peak_q;
  end

  assign emit_o = (above && line_end) || (open_q && !above);

  always_comb begin
    span_o.x = {pix_i.origin_x[OrigW-1], pix_i.origin_x} +
               PosW'({start_eff, {FracBits{1'b0}}});
    span_o.y = {pix_i.origin_y[OrigW-1], pix_i.origin_y} +
               PosW'({row_q, {FracBits{1'b0}}});
    span_o.width = SpanWW'({1'b0, column_q}) - SpanWW'({1'b0, start_eff}) +
                   SpanWW'(above);
    span_o.peak = peak_out;
  end

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    open_d   = open_q;
    start_d  = start_q;
    peak_d   = peak_q;
    if (advance_i) begin
      open_d = above;
      if (above) begin
        start_d = start_eff;
        peak_d  = peak_eff;
      end
      if (pix_i.glyph_end) begin
        column_d = '0;
        row_d    = '0;
        open_d   = 1'b0;
      end else if (line_end) begin
        column_d = '0;
        open_d   = 1'b0;
        row_d    = (row_q == RowW'(MaxHeight - 1)) ? '0 : row_q + 1'b1;
      end else begin
        column_d = column_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      open_q   <= 1'b0;
      start_q  <= '0;
      peak_q   <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
      open_q   <= open_d;
      start_q  <= start_d;
      peak_q   <= peak_d;
    end
  end

endmodule

// ----- hw/rtl/rspan_out_stage.sv -----
`timescale 1ns / 1ps

module rspan_out_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  rspan_pkg::span_t             span_i,
  input  logic [rspan_pkg::CfgW-1:0]   base_alpha_i,
  output logic                         free_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [rspan_pkg::PosW-1:0] span_x_o,
  output logic signed [rspan_pkg::PosW-1:0] span_y_o,
  output logic [rspan_pkg::SpanWW-1:0] span_width_o,
  output logic [rspan_pkg::PixW-1:0]   span_alpha_o
);
  import rspan_pkg::*;

  logic                   valid_q;
  logic signed [PosW-1:0] x_q, y_q;
  logic [SpanWW-1:0]      width_q;
  logic [PixW-1:0]        alpha_q, alpha_d;
  logic [2*PixW-1:0]      prod;
  logic [2*PixW:0]        scaled;

  // divide by 255: (p + (p >> 8) + 1) >> 8, exact for p up to 255 * 255
  assign prod    = base_alpha_i * span_i.peak;
  assign scaled  = {1'b0, prod} + (2*PixW+1)'(prod[2*PixW-1:PixW]) + 1'b1;
  assign alpha_d = scaled[2*PixW-1:PixW];

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      x_q     <= span_i.x;
      y_q     <= span_i.y;
      width_q <= span_i.width;
      alpha_q <= alpha_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign span_x_o     = x_q;
  assign span_y_o     = y_q;
  assign span_width_o = width_q;
  assign span_alpha_o = alpha_q;

endmodule
